[design/bdsm_pkg.sv]
package bdsm_pkg;

  localparam logic [1:0] CMD_PUSH = 2'd0;
  localparam logic [1:0] CMD_TAKE = 2'd1;
  localparam logic [1:0] CMD_SHOW = 2'd2;
  localparam logic [1:0] CMD_ADD  = 2'd3;

  localparam logic [1:0] KIND_TAKEN  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ENTRY  = 2'd2;
  localparam logic [1:0] KIND_ERROR  = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW  = 2'd1;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd2;
  localparam logic [1:0] ERR_HALTED    = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [63:0] push_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] value;
    logic [1:0]         error_code;
    logic               last;
  } out_item_t;

endpackage

[design/bdsm_if.sv]
interface bdsm_in_if;
  import bdsm_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface bdsm_out_if;
  import bdsm_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[design/bounded_data_stack_machine.sv]
// Decoded stack-machine commands run on a data stack of STACK_DEPTH signed 64-bit
// entries held in a RAM with one write port and one registered read port; a small
// sequencer drives that port and one 64-bit adder. A command is taken only while
// the sequencer is idle. A successful push is written from idle; a removal reads
// the top entry and returns it; an add writes the sum of the top two entries back;
// a show returns a header and then the entries, one result per cycle while the
// output register can be freed, since every entry must pass through the single
// read port. Results wait in it, and emitting stalls while it cannot be freed.
// After an overflow or underflow every command returns a halted error until reset.
module bounded_data_stack_machine #(
  parameter int STACK_DEPTH = 8
) (
  input logic         clk,
  input logic         rst_n,
  bdsm_in_if.sink     in_ch,
  bdsm_out_if.source  out_ch
);
  import bdsm_pkg::*;

  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [DW-1:0] DEPTH_FULL = DW'(STACK_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_TAKE_EMIT,
    ST_SHOW_HDR,
    ST_SHOW_ENT,
    ST_ADD_B,
    ST_ADD_SUM
  } state_t;

  state_t             state_r, state_nxt;
  logic [DW-1:0]      depth_r, depth_nxt;
  logic               halted_r, halted_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [63:0]        acc_r, acc_nxt;
  logic [1:0]         err_r, err_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [63:0]        mem [STACK_DEPTH];
  logic [63:0]        rd_data_r;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [63:0]        wr_data;

  logic               out_free;
  logic               emit;
  out_item_t          emit_data;
  logic [AW-1:0]      top_addr, second_addr;
  logic [DW-1:0]      depth_m1, depth_m2;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign depth_m1    = depth_r - DW'(1);
  assign depth_m2    = depth_r - DW'(2);
  assign top_addr    = depth_m1[AW-1:0];
  assign second_addr = depth_m2[AW-1:0];

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  always_comb begin
    state_nxt  = state_r;
    depth_nxt  = depth_r;
    halted_nxt = halted_r;
    idx_nxt    = idx_r;
    acc_nxt    = acc_r;
    err_nxt    = err_r;
    emit       = 1'b0;
    emit_data  = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (halted_r) begin
            err_nxt   = ERR_HALTED;
            state_nxt = ST_ERR;
          end else begin
            case (in_ch.data.command)
              CMD_PUSH: begin
                if (depth_r == DEPTH_FULL) begin
                  err_nxt    = ERR_OVERFLOW;
                  halted_nxt = 1'b1;
                  state_nxt  = ST_ERR;
                end else begin
                  wr_en     = 1'b1;
                  wr_addr   = depth_r[AW-1:0];
                  wr_data   = in_ch.data.push_value;
                  depth_nxt = depth_r + DW'(1);
                end
              end
              CMD_TAKE: begin
                if (depth_r == '0) begin
                  err_nxt    = ERR_UNDERFLOW;
                  halted_nxt = 1'b1;
                  state_nxt  = ST_ERR;
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = top_addr;
                  state_nxt = ST_TAKE_EMIT;
                end
              end
              CMD_SHOW: begin
                state_nxt = ST_SHOW_HDR;
              end
              CMD_ADD: begin
                if (depth_r < DW'(2)) begin
                  err_nxt    = ERR_UNDERFLOW;
                  halted_nxt = 1'b1;
                  state_nxt  = ST_ERR;
                end else begin
                  rd_en     = 1'b1;
                  rd_addr   = top_addr;
                  state_nxt = ST_ADD_B;
                end
              end
              default: begin
                state_nxt = ST_IDLE;
              end
            endcase
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          emit                 = 1'b1;
          emit_data.kind       = KIND_ERROR;
          emit_data.error_code = err_r;
          emit_data.last       = 1'b1;
          state_nxt            = ST_IDLE;
        end
      end
      ST_TAKE_EMIT: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_data.kind  = KIND_TAKEN;
          emit_data.value = rd_data_r;
          emit_data.last  = 1'b1;
          depth_nxt       = depth_m1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_SHOW_HDR: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_data.kind  = KIND_HEADER;
          emit_data.value = 64'(depth_r);
          emit_data.last  = (depth_r == '0);
          if (depth_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = '0;
            idx_nxt   = '0;
            state_nxt = ST_SHOW_ENT;
          end
        end
      end
      ST_SHOW_ENT: begin
        if (out_free) begin
          emit            = 1'b1;
          emit_data.kind  = KIND_ENTRY;
          emit_data.value = rd_data_r;
          emit_data.last  = (idx_r == top_addr);
          if (idx_r == top_addr) begin
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      ST_ADD_B: begin
        acc_nxt   = rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = second_addr;
        state_nxt = ST_ADD_SUM;
      end
      ST_ADD_SUM: begin
        wr_en     = 1'b1;
        wr_addr   = second_addr;
        wr_data   = acc_r + rd_data_r;
        depth_nxt = depth_m1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      depth_r     <= '0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      depth_r  <= depth_nxt;
      halted_r <= halted_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
    idx_r <= idx_nxt;
    acc_r <= acc_nxt;
    err_r <= err_nxt;
    if (emit) begin
      out_data_r <= emit_data;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= DEPTH_FULL)
    else $error("stack depth beyond capacity");

  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.ready && out_ch.data.kind == KIND_ERROR) |-> halted_r)
    else $error("error result transferred while not halted");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halted flag cleared without reset");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && !halted_r && in_ch.data.command == CMD_PUSH
     && depth_r != DEPTH_FULL) |=> (depth_r == $past(depth_r) + DW'(1)))
    else $error("push did not grow the stack");

  a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && state_r == ST_IDLE) |=> $stable(depth_r))
    else $error("stack depth changed while halted");

endmodule

[tb/tb_bounded_data_stack_machine.sv]
module tb_bounded_data_stack_machine;
  timeunit 1ns;
  timeprecision 1ps;

  import bdsm_pkg::*;

  localparam int DEPTH = 8;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = DEPTH + 8;
  localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

  logic clk = 1'b0;
  logic rst_n;

  bdsm_in_if  in_ch();
  bdsm_out_if out_ch();

  bounded_data_stack_machine #(
    .STACK_DEPTH(DEPTH)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  logic signed [63:0] model_stack [DEPTH];
  int                 model_depth;
  bit                 model_halted;

  out_item_t pending_results[$];

  int    src_idle_pct;
  int    sink_idle_pct;
  int    holdoff_left;
  int    commands_sent;
  int    results_checked;
  int    failures;
  int    cycle_count;
  string halt_cause;

  function automatic out_item_t make_result(logic [1:0] kind, logic signed [63:0] value,
                                            logic [1:0] code, logic fin);
    out_item_t r;
    r.kind       = kind;
    r.value      = value;
    r.error_code = code;
    r.last       = fin;
    return r;
  endfunction

  function automatic void halt_with(logic [1:0] code);
    model_halted = 1'b1;
    pending_results.push_back(make_result(KIND_ERROR, '0, code, 1'b1));
  endfunction

  function automatic void execute_command(in_item_t it);
    if (model_halted) begin
      pending_results.push_back(make_result(KIND_ERROR, '0, ERR_HALTED, 1'b1));
      return;
    end
    case (it.command)
      CMD_PUSH: begin
        if (model_depth >= DEPTH) begin
          halt_with(ERR_OVERFLOW);
        end else begin
          model_stack[model_depth] = it.push_value;
          model_depth++;
        end
      end
      CMD_TAKE: begin
        if (model_depth == 0) begin
          halt_with(ERR_UNDERFLOW);
        end else begin
          model_depth--;
          pending_results.push_back(make_result(KIND_TAKEN, model_stack[model_depth],
                                                ERR_NONE, 1'b1));
        end
      end
      CMD_SHOW: begin
        pending_results.push_back(make_result(KIND_HEADER, 64'(model_depth), ERR_NONE,
                                              model_depth == 0));
        for (int k = 0; k < model_depth; k++) begin
          pending_results.push_back(make_result(KIND_ENTRY, model_stack[k], ERR_NONE,
                                                k == model_depth - 1));
        end
      end
      default: begin
        if (model_depth < 2) begin
          halt_with(ERR_UNDERFLOW);
        end else begin
          model_stack[model_depth-2] = model_stack[model_depth-1] + model_stack[model_depth-2];
          model_depth--;
        end
      end
    endcase
  endfunction

  function automatic logic signed [63:0] pick_value();
    case ($urandom_range(7))
      0: return VAL_MAX;
      1: return VAL_MIN;
      2: return '0;
      3: return -64'sd1;
      4: return 64'($urandom_range(100));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Steers a random command away from anything that would halt the machine.
  function automatic logic [1:0] pick_legal_command();
    logic [1:0] c;
    c = 2'($urandom_range(3));
    if (c == CMD_PUSH && model_depth >= DEPTH) c = CMD_ADD;
    if (c == CMD_TAKE && model_depth == 0) c = CMD_PUSH;
    if (c == CMD_ADD && model_depth < 2) c = CMD_PUSH;
    return c;
  endfunction

  task automatic send_command(logic [1:0] cmd, logic signed [63:0] val);
    in_item_t it;
    it.command    = cmd;
    it.push_value = val;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    execute_command(it);
    commands_sent++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed_edges();
    logic signed [63:0] fill [DEPTH];
    fill = '{VAL_MAX, VAL_MIN, '0, -64'sd1, 64'sh5555_5555_5555_5555,
             64'shAAAA_AAAA_AAAA_AAAA, 64'sd1, {$urandom, $urandom}};
    send_command(CMD_SHOW, pick_value());
    send_command(CMD_PUSH, VAL_MAX);
    send_command(CMD_PUSH, 64'sd1);
    send_command(CMD_ADD, pick_value());
    send_command(CMD_TAKE, pick_value());
    send_command(CMD_PUSH, VAL_MIN);
    send_command(CMD_PUSH, VAL_MIN);
    send_command(CMD_ADD, pick_value());
    send_command(CMD_TAKE, pick_value());
    send_command(CMD_PUSH, -64'sd1);
    send_command(CMD_PUSH, 64'sh5555_5555_5555_5555);
    send_command(CMD_SHOW, pick_value());
    send_command(CMD_TAKE, pick_value());
    send_command(CMD_TAKE, pick_value());
    for (int k = 0; k < DEPTH; k++) send_command(CMD_PUSH, fill[k]);
    send_command(CMD_SHOW, pick_value());
    settle();
  endtask

  task automatic test_random_traffic(int src_pct, int sink_pct, int count);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    repeat (count) send_command(pick_legal_command(), pick_value());
    settle();
  endtask

  task automatic test_output_backpressure();
    src_idle_pct = 0;
    holdoff_left = 150;
    while (model_depth < DEPTH - 2) send_command(CMD_PUSH, pick_value());
    repeat (6) send_command(CMD_SHOW, pick_value());
    send_command(CMD_TAKE, pick_value());
    settle();
  endtask

  task automatic test_halt_and_after();
    int target;
    case ($urandom_range(2))
      0: begin
        halt_cause = "a push on a full stack";
        while (model_depth < DEPTH) send_command(CMD_PUSH, pick_value());
        send_command(CMD_PUSH, pick_value());
      end
      1: begin
        halt_cause = "a take from an empty stack";
        while (model_depth > 0) send_command(CMD_TAKE, pick_value());
        send_command(CMD_TAKE, pick_value());
      end
      default: begin
        halt_cause = "an add on a short stack";
        target = $urandom_range(1);
        while (model_depth > target) send_command(CMD_TAKE, pick_value());
        while (model_depth < target) send_command(CMD_PUSH, pick_value());
        send_command(CMD_ADD, pick_value());
      end
    endcase
    repeat (12) send_command(2'($urandom_range(3)), pick_value());
    settle();
  endtask

  initial begin
    out_item_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d value %0d error_code %0d last %0d",
                 out_ch.data.kind, out_ch.data.value, out_ch.data.error_code,
                 out_ch.data.last);
          failures++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          results_checked++;
          if (out_ch.data.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_ch.data.kind);
            failures++;
          end
          if (out_ch.data.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_ch.data.value);
            failures++;
          end
          if (out_ch.data.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code,
                   out_ch.data.error_code);
            failures++;
          end
          if (out_ch.data.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.data.last);
            failures++;
          end
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    model_depth    = 0;
    model_halted   = 1'b0;
    holdoff_left   = 0;
    src_idle_pct   = 19;
    sink_idle_pct  = 84;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_random_traffic(19, 84, 40);
    test_random_traffic(84, 19, 40);
    test_random_traffic(0, 0, 40);
    test_output_backpressure();
    test_halt_and_after();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d commands with %0d results checked: extreme values, wrapping sums,",
             commands_sent, results_checked);
    $display("full-depth shows, a long output stall, and a halt caused by %s.", halt_cause);
    if (failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
